// ===== design/gst_pkg.sv =====
package gst_pkg;

    localparam logic [15:0] EMPTY_MARK = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

// ===== design/gst_ctrl.sv =====
module gst_ctrl
    import gst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // take the next beat in the same cycle the held result leaves
    assign o_in_ready  = (r_state == S_IDLE) || ((r_state == S_HOLD) && i_out_ready);
    assign o_out_valid = (r_state == S_HOLD);
    assign o_cmd.load  = i_in_valid && o_in_ready;
    assign o_cmd.exec  = (r_state == S_EXEC);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_HOLD;
            end
            S_HOLD: begin
                if (i_out_ready) n_state = i_in_valid ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/gst_datapath.sv =====
module gst_datapath
    import gst_pkg::*;
#(
    parameter int SLOT_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_op         i_op,
    input  logic [15:0] i_group_id,
    input  logic [15:0] i_primary_group,
    output logic        o_status,
    output logic        o_is_member,
    output logic [4:0]  o_entry_count
);

    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [15:0]   r_slot [SLOT_COUNT];
    logic [15:0]   n_slot [SLOT_COUNT];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    t_op           r_op;
    logic [15:0]   r_id;
    logic          r_status;
    logic          n_status;
    logic          r_member;
    logic          n_member;

    logic [SLOT_COUNT-1:0]      eq;
    logic [(SLOT_COUNT+1)*16-1:0] upper;
    logic [IW-1:0]              hit_idx;
    logic                       present;
    logic                       full;
    logic [CW+4:0]              count_ext;

    // occupied slots stay packed at the bottom and hold each id at most once,
    // so the first empty slot sits at r_count and a hit index is a plain OR
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            eq[i] = (r_slot[i] == r_id);
            if (eq[i]) hit_idx = hit_idx | IW'(i);
            upper[i*16 +: 16] = r_slot[i];
        end
        upper[SLOT_COUNT*16 +: 16] = EMPTY_MARK;
        present = (|eq) && (r_id != EMPTY_MARK);
        full    = (r_count == CW'(SLOT_COUNT));
    end

    always_comb begin
        n_slot   = r_slot;
        n_count  = r_count;
        n_status = 1'b0;
        n_member = 1'b0;
        unique case (r_op)
            OP_INSERT: begin
                if (r_id == EMPTY_MARK) begin
                    n_status = full;
                end else if (!present) begin
                    if (full) begin
                        n_status = 1'b1;
                    end else begin
                        for (int i = 0; i < SLOT_COUNT; i++) begin
                            if (CW'(i) == r_count) n_slot[i] = r_id;
                        end
                        n_count = r_count + CW'(1);
                    end
                end
            end
            OP_REMOVE: begin
                // close the gap: every slot from the hit on takes its upper neighbour
                if (present) begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (IW'(i) >= hit_idx) n_slot[i] = upper[(i+1)*16 +: 16];
                    end
                    n_count = r_count - CW'(1);
                end
            end
            OP_LOOKUP: begin
                n_member = (i_primary_group == r_id) || present;
            end
            OP_CLEAR: begin
                for (int i = 0; i < SLOT_COUNT; i++) n_slot[i] = EMPTY_MARK;
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_id <= i_group_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) r_slot[i] <= EMPTY_MARK;
            r_count  <= '0;
            r_status <= 1'b0;
            r_member <= 1'b0;
        end else if (i_cmd.exec) begin
            r_slot   <= n_slot;
            r_count  <= n_count;
            r_status <= n_status;
            r_member <= n_member;
        end
    end

    assign count_ext     = {5'b0, r_count};
    assign o_entry_count = count_ext[4:0];
    assign o_status      = r_status;
    assign o_is_member   = r_member;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOT_COUNT))
        else $error("slot count beyond table depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_op == OP_CLEAR) |=> (r_count == '0))
        else $error("clear left occupied slots");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_status |-> (r_count == CW'(SLOT_COUNT)))
        else $error("full reported while a slot is free");

endmodule

// ===== design/group_set_table.sv =====
// Group set table. One item per beat on the slave stream (tuser carries the
// operation, tdata the group id) gives one result beat on the master stream.
// An item is first taken in (op and id registered), then the table is updated
// in S_EXEC, where all slots are compared at once and a remove shifts the tail
// down in a single step; the result is held in S_HOLD. The next item is taken
// in the cycle its predecessor's result leaves, never before. The table comes
// out of reset empty; no clearing pass is needed.
module group_set_table
    import gst_pkg::*;
#(
    parameter int SLOT_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] group_id
    input  logic [1:0]  s_tuser,   // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] status, [1] is_member, [6:2] entry_count, [7] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_PRIMARY = 1'b0;

    t_cmd        cmd;
    logic [15:0] r_primary_group;
    logic        status;
    logic        is_member;
    logic [4:0]  entry_count;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PRIMARY) ? {16'b0, r_primary_group} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primary_group <= 16'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_PRIMARY) begin
            r_primary_group <= pwdata[15:0];
        end
    end

    gst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .o_cmd       (cmd)
    );

    gst_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_op            (t_op'(s_tuser)),
        .i_group_id      (s_tdata),
        .i_primary_group (r_primary_group),
        .o_status        (status),
        .o_is_member     (is_member),
        .o_entry_count   (entry_count)
    );

    assign m_tdata = {1'b0, entry_count, is_member, status};

endmodule
